@@ hw/rtl/dotq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotq_pkg
// Shared types and constants of the deadline-ordered timer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned TagBits    = 16;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned CountBits  = 4;

  typedef enum logic [1:0] {
    OpPush  = 2'd0,
    OpPop   = 2'd1,
    OpQuery = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StatEmpty   = 2'd0,
    StatDue     = 2'd1,
    StatWaiting = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [TimeBits-1:0] current_time;
    logic [TimeBits-1:0] deadline;
    logic [TagBits-1:0]  task_tag;
  } req_t;

  typedef struct packed {
    logic                 push_accepted;
    logic                 pop_valid;
    logic [TagBits-1:0]   popped_tag;
    logic [1:0]           idle_status;
    logic [TimeBits-1:0]  remaining_time;
    logic [CountBits-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic                valid;
    logic [TimeBits-1:0] deadline;
    logic [TagBits-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [TimeBits-1:0] deadline;
    logic [TagBits-1:0]  tag;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/dotq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotq_cell
// One slot of the sorted queue. It keeps its entry, takes the new word, or
// takes the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module dotq_cell
  import dotq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       stay_left_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  output logic       stay_o,
  output entry_t     entry_o
);

  entry_t entry_d;
  entry_t entry_q;

  assign stay_o = entry_q.valid && (entry_q.deadline <= ctrl_i.deadline);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (!stay_o) begin
        if (stay_left_i) begin
          entry_d.valid    = 1'b1;
          entry_d.deadline = ctrl_i.deadline;
          entry_d.tag      = ctrl_i.tag;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ hw/rtl/deadline_ordered_timer_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_ordered_timer_queue_unit
// Sorted deadline queue built from a row of cells, earliest deadline in
// cell zero.
//
//   Port     Dir  Handshake         Payload
//   start_i  in   start_i & !busy_o req_i (req_t)
//   done_o   out  one-cycle strobe  rsp_o (rsp_t)
//
// Each word is accepted as it arrives and its result appears on the next cycle.
// A new word may be started in every cycle; all cells compare against the
// pushed deadline in parallel, so push, pop and query need no sequential pass.
// Reset empties the queue at once; no clearing pass is needed.
// Results cannot be stalled; busy_o is never raised.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue_unit
  import dotq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cell_ctrl_t ctrl;
  entry_t     cells   [QueueDepth];
  logic       stay    [QueueDepth];
  logic [QueueDepth-1:0] valid_vec;

  logic [CntW-1:0] count_d, count_q;
  logic            accept, full, head_due;
  rsp_t            rsp_d, rsp_q;
  logic            done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = cells[QueueDepth-1].valid;
  assign head_due = cells[0].valid && (cells[0].deadline <= req_i.current_time);

  always_comb begin
    ctrl.push     = accept && (req_i.operation == OpPush) && !full;
    ctrl.pop      = accept && (req_i.operation == OpPop) && head_due;
    ctrl.deadline = req_i.deadline;
    ctrl.tag      = req_i.task_tag;
  end

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    entry_t left, right;
    logic   stay_left;
    if (i == 0) begin : g_first
      assign left      = '0;
      assign stay_left = 1'b1;
    end else begin : g_mid
      assign left      = cells[i-1];
      assign stay_left = stay[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end
    dotq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .stay_left_i (stay_left),
      .left_i      (left),
      .right_i     (right),
      .stay_o      (stay[i]),
      .entry_o     (cells[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
    end

    rsp_d               = '0;
    rsp_d.entry_count   = CountBits'(count_d);
    case (req_i.operation)
      OpPush: begin
        rsp_d.push_accepted = !full;
      end
      OpPop: begin
        if (head_due) begin
          rsp_d.pop_valid  = 1'b1;
          rsp_d.popped_tag = cells[0].tag;
        end
      end
      OpQuery: begin
        if (!cells[0].valid) begin
          rsp_d.idle_status = StatEmpty;
        end else if (head_due) begin
          rsp_d.idle_status = StatDue;
        end else begin
          rsp_d.idle_status    = StatWaiting;
          rsp_d.remaining_time = cells[0].deadline - req_i.current_time;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  for (genvar i = 0; i + 1 < QueueDepth; i++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
        cells[i+1].valid |-> cells[i].valid)
      else $error("Queue has a hole in its occupied cells.");
    assert property (@(posedge clk_i) disable iff (!rst_ni)
        cells[i+1].valid |-> (cells[i].deadline <= cells[i+1].deadline))
      else $error("Queue entries are out of deadline order.");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $countones(valid_vec) == int'(count_q))
    else $error("Entry count disagrees with occupied cells.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept && (req_i.operation == OpPush) && full) |=> $stable(valid_vec))
    else $error("Rejected push changed the queue.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctrl.pop |-> cells[0].valid)
    else $error("Pop issued on an empty queue.");

endmodule
